// ===== design/sfd_pkg.sv =====
// Shared constants and result type for the serial frame deframer and checker.
package sfd_pkg;

  localparam logic [7:0] SYNC_A = 8'hAA;
  localparam logic [7:0] SYNC_B = 8'h55;

  // Body bytes ahead of the payload: source, destination, ack flag, function
  localparam int unsigned HDR_BYTES = 4;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TRAILER  = 2'd1,
    ST_CHECKSUM = 2'd2,
    ST_SHORT    = 2'd3
  } frame_status_t;

  typedef struct packed {
    logic          payload_valid;
    logic [7:0]    payload_byte;
    logic          frame_done;
    frame_status_t frame_status;
    logic          ack_wanted;
    logic [7:0]    source_id;
    logic [7:0]    dest_id;
    logic [7:0]    func_code;
  } result_t;

endpackage

// ===== design/serial_frame_deframer_checker_core.sv =====
// Serial frame deframer and checker, top level.
//
// Takes one received byte per transaction and returns exactly one result
// transaction per byte, in order. Frames are AA 55, length L, L body bytes
// (source id, destination id, ack flag, function code, payload), an XOR
// checksum of L and the body, and trailer 55 AA. Payload bytes come out with
// m_tuser set; the last trailer byte comes out with m_tlast set and carries
// the status (trailer error over length-too-short over checksum error), the
// header ids and the ack request. Other bytes give an all-zero result. A
// byte passes from the input register through the combinational parser
// update into the result register, and one byte can be taken every cycle
// while m_tready keeps up. An accepted byte is held in the input register
// while the result register waits on m_tready.
module serial_frame_deframer_checker_core
  import sfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] payload_byte, [9:8] frame_status,
                                 // [10] ack_wanted, [18:11] source_id,
                                 // [26:19] dest_id, [34:27] func_code, [39:35] 0
  output logic        m_tuser,   // [0] payload_valid
  output logic        m_tlast    // frame_done
);

  logic       advance;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       step;
  result_t    res;

  assign step = in_valid && advance;

  sfd_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .advance  (advance),
    .in_valid (in_valid),
    .in_byte  (in_byte)
  );

  sfd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (in_byte),
    .res     (res)
  );

  sfd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .res      (res),
    .advance  (advance),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== design/sfd_in_reg.sv =====
// Input register: holds one received byte until the parser takes it.
module sfd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  input  logic       advance,
  output logic       in_valid,
  output logic [7:0] in_byte
);

  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

endmodule

// ===== design/sfd_parser.sv =====
// Frame parser: sync hunt, length/body/checksum/trailer sequencing and status.
module sfd_parser
  import sfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output result_t    res
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_GOT_AA,
    PH_LEN,
    PH_BODY,
    PH_CSUM,
    PH_TRL1,
    PH_TRL2
  } phase_t;

  localparam logic [2:0] IDX_MAX = 3'(HDR_BYTES);

  phase_t     phase, phase_next;
  logic [7:0] body_left, body_left_next;
  logic [2:0] body_index, body_index_next;   // saturates once the header is done
  logic [7:0] running_xor, running_xor_next;
  logic       checksum_bad, checksum_bad_next;
  logic       trailer_bad, trailer_bad_next;
  logic [7:0] held_source, held_source_next;
  logic [7:0] held_dest, held_dest_next;
  logic [7:0] held_ack_flag, held_ack_flag_next;
  logic [7:0] held_func, held_func_next;
  logic       tbad;

  always_comb begin
    res                = '0;
    phase_next         = phase;
    body_left_next     = body_left;
    body_index_next    = body_index;
    running_xor_next   = running_xor;
    checksum_bad_next  = checksum_bad;
    trailer_bad_next   = trailer_bad;
    held_source_next   = held_source;
    held_dest_next     = held_dest;
    held_ack_flag_next = held_ack_flag;
    held_func_next     = held_func;
    tbad               = trailer_bad || (rx_byte != SYNC_A);

    case (phase)
      PH_HUNT: begin
        if (rx_byte == SYNC_A) begin
          phase_next = PH_GOT_AA;
        end
      end
      PH_GOT_AA: begin
        if (rx_byte == SYNC_B) begin
          phase_next = PH_LEN;
        end else if (rx_byte != SYNC_A) begin
          phase_next = PH_HUNT;
        end
      end
      PH_LEN: begin
        body_left_next     = rx_byte;
        body_index_next    = '0;
        running_xor_next   = rx_byte;
        checksum_bad_next  = 1'b0;
        trailer_bad_next   = 1'b0;
        held_source_next   = '0;
        held_dest_next     = '0;
        held_ack_flag_next = '0;
        held_func_next     = '0;
        // zero length: the next byte is the checksum
        phase_next = (rx_byte == '0) ? PH_CSUM : PH_BODY;
      end
      PH_BODY: begin
        running_xor_next = running_xor ^ rx_byte;
        case (body_index)
          3'd0:    held_source_next   = rx_byte;
          3'd1:    held_dest_next     = rx_byte;
          3'd2:    held_ack_flag_next = rx_byte;
          3'd3:    held_func_next     = rx_byte;
          default: begin
            res.payload_valid = 1'b1;
            res.payload_byte  = rx_byte;
          end
        endcase
        if (body_index != IDX_MAX) begin
          body_index_next = body_index + 3'd1;
        end
        body_left_next = body_left - 8'd1;
        if (body_left == 8'd1) begin
          phase_next = PH_CSUM;
        end
      end
      PH_CSUM: begin
        checksum_bad_next = (rx_byte != running_xor);
        phase_next        = PH_TRL1;
      end
      PH_TRL1: begin
        if (rx_byte != SYNC_B) begin
          trailer_bad_next = 1'b1;
        end
        phase_next = PH_TRL2;
      end
      PH_TRL2: begin
        trailer_bad_next = tbad;
        res.frame_done   = 1'b1;
        if (tbad) begin
          res.frame_status = ST_TRAILER;
        end else if (body_index != IDX_MAX) begin
          res.frame_status = ST_SHORT;
        end else if (checksum_bad) begin
          res.frame_status = ST_CHECKSUM;
        end else begin
          res.frame_status = ST_OK;
        end
        res.ack_wanted = (res.frame_status == ST_OK) && (held_ack_flag != '0);
        res.source_id  = held_source;
        res.dest_id    = held_dest;
        res.func_code  = held_func;
        phase_next     = PH_HUNT;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      body_left    <= '0;
      body_index   <= '0;
      checksum_bad <= 1'b0;
      trailer_bad  <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      body_left    <= body_left_next;
      body_index   <= body_index_next;
      checksum_bad <= checksum_bad_next;
      trailer_bad  <= trailer_bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      running_xor   <= running_xor_next;
      held_source   <= held_source_next;
      held_dest     <= held_dest_next;
      held_ack_flag <= held_ack_flag_next;
      held_func     <= held_func_next;
    end
  end

endmodule

// ===== design/sfd_out_reg.sv =====
// Result register driving the master-side stream.
module sfd_out_reg
  import sfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  result_t     res,
  output logic        advance,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  output logic        m_tuser,
  output logic        m_tlast
);

  result_t held;

  assign advance = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step) begin
      held <= res;
    end
  end

  assign m_tuser = held.payload_valid;
  assign m_tlast = held.frame_done;
  assign m_tdata = {5'd0, held.func_code, held.dest_id, held.source_id,
                    held.ack_wanted, held.frame_status, held.payload_byte};

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the serial frame deframer and checker core.
`timescale 1ns / 100ps

module testbench
  import sfd_pkg::*;
();

  typedef enum logic [2:0] {
    PH_HUNT, PH_GOT_AA, PH_LEN, PH_BODY, PH_CSUM, PH_TRL1, PH_TRL2
  } parse_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  serial_frame_deframer_checker_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Frame parser mirror
  parse_phase_t parse_phase = PH_HUNT;
  logic [7:0]   bytes_left = 8'h00;
  logic [7:0]   body_count = 8'h00;
  logic [7:0]   xor_acc = 8'h00;
  logic         csum_mismatch = 1'b0;
  logic         trailer_mismatch = 1'b0;
  logic [7:0]   hdr_source = 8'h00;
  logic [7:0]   hdr_dest = 8'h00;
  logic [7:0]   hdr_ack = 8'h00;
  logic [7:0]   hdr_func = 8'h00;

  result_t expected_results[$];
  int      mismatches = 0;
  int      bytes_sent = 0;
  int      burst_left = 0;
  bit      sender_gaps = 1'b1;
  int      rx_hold_req = 0;
  int      rx_hold_left = 0;
  int      rx_stall_pct = 0;
  int      rx_cycle = 0;

  task automatic parse_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    case (parse_phase)
      PH_HUNT: begin
        if (b == SYNC_A) parse_phase = PH_GOT_AA;
      end
      PH_GOT_AA: begin
        if (b == SYNC_B) parse_phase = PH_LEN;
        else if (b != SYNC_A) parse_phase = PH_HUNT;
      end
      PH_LEN: begin
        bytes_left = b;
        body_count = 8'h00;
        xor_acc = b;
        csum_mismatch = 1'b0;
        trailer_mismatch = 1'b0;
        hdr_source = 8'h00;
        hdr_dest = 8'h00;
        hdr_ack = 8'h00;
        hdr_func = 8'h00;
        parse_phase = (b == 8'h00) ? PH_CSUM : PH_BODY;
      end
      PH_BODY: begin
        xor_acc = xor_acc ^ b;
        case (body_count)
          8'd0: hdr_source = b;
          8'd1: hdr_dest = b;
          8'd2: hdr_ack = b;
          8'd3: hdr_func = b;
          default: begin
            r.payload_valid = 1'b1;
            r.payload_byte = b;
          end
        endcase
        body_count = body_count + 8'd1;
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'h00) parse_phase = PH_CSUM;
      end
      PH_CSUM: begin
        csum_mismatch = (b != xor_acc);
        parse_phase = PH_TRL1;
      end
      PH_TRL1: begin
        if (b != SYNC_B) trailer_mismatch = 1'b1;
        parse_phase = PH_TRL2;
      end
      PH_TRL2: begin
        if (b != SYNC_A) trailer_mismatch = 1'b1;
        // trailer error beats short length beats checksum error
        if (trailer_mismatch) r.frame_status = ST_TRAILER;
        else if (body_count < HDR_BYTES) r.frame_status = ST_SHORT;
        else if (csum_mismatch) r.frame_status = ST_CHECKSUM;
        else r.frame_status = ST_OK;
        r.frame_done = 1'b1;
        r.ack_wanted = (r.frame_status == ST_OK) && (hdr_ack != 8'h00);
        r.source_id = hdr_source;
        r.dest_id = hdr_dest;
        r.func_code = hdr_func;
        parse_phase = PH_HUNT;
      end
      default: parse_phase = PH_HUNT;
    endcase
    expected_results.push_back(r);
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (sender_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 2) != 0) begin
        gap = $urandom_range(1, 8);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    parse_byte(b);
  endtask

  task automatic send_frame(input logic [7:0] len, src, dst, ack, func, csum_flip,
                            trl1, trl2, input int extra_aa);
    logic [7:0] hdr [4];
    logic [7:0] b;
    logic [7:0] sum;
    int i;
    hdr[0] = src;
    hdr[1] = dst;
    hdr[2] = ack;
    hdr[3] = func;
    repeat (extra_aa) send_byte(SYNC_A);
    send_byte(SYNC_A);
    send_byte(SYNC_B);
    send_byte(len);
    sum = len;
    for (i = 0; i < len; i++) begin
      if (i < HDR_BYTES) b = hdr[i];
      else b = 8'($urandom);
      sum = sum ^ b;
      send_byte(b);
    end
    send_byte(sum ^ csum_flip);
    send_byte(trl1);
    send_byte(trl2);
  endtask

  // Hold the input idle until every outstanding result has come back
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 3))
      0: return SYNC_A;
      1: return SYNC_B;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic check_field(input string field, input logic [7:0] want, got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      $display({"%0t: result with nothing expected: expected none, ",
                "actual tdata %0h tuser %0b tlast %0b"},
               $time, m_tdata, m_tuser, m_tlast);
    end else begin
      want = expected_results.pop_front();
      check_field("payload_valid", want.payload_valid, m_tuser);
      check_field("payload_byte", want.payload_byte, m_tdata[7:0]);
      check_field("frame_done", want.frame_done, m_tlast);
      check_field("frame_status", want.frame_status, m_tdata[9:8]);
      check_field("ack_wanted", want.ack_wanted, m_tdata[10]);
      check_field("source_id", want.source_id, m_tdata[18:11]);
      check_field("dest_id", want.dest_id, m_tdata[26:19]);
      check_field("func_code", want.func_code, m_tdata[34:27]);
    end
  endtask

  // Result side: check each transaction, then pick next cycle's tready
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (rx_hold_req > 0) begin
        rx_hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      rx_cycle++;
      if (rx_cycle % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: rx_stall_pct = 0;
          1: rx_stall_pct = 20;
          2: rx_stall_pct = 50;
          default: rx_stall_pct = 85;
        endcase
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  task automatic test_hunting();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_B);
    send_byte(SYNC_A);
    send_byte(8'h12);
    // repeated sync bytes keep the parser armed
    send_frame(8'd5, 8'h21, 8'h43, 8'h01, 8'h65, 8'h00, SYNC_B, SYNC_A, 2);
  endtask

  task automatic test_good_frames();
    send_frame(8'd4, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h00, SYNC_B, SYNC_A, 0);
    send_frame(8'd7, 8'hFF, 8'h00, 8'h00, 8'h7F, 8'h00, SYNC_B, SYNC_A, 0);
  endtask

  task automatic test_status_codes();
    send_frame(8'd4, 8'h01, 8'h02, 8'hFF, 8'h03, 8'h01, SYNC_B, SYNC_A, 0);
    send_frame(8'd5, 8'h04, 8'h05, 8'h01, 8'h06, 8'h00, 8'h54, SYNC_A, 0);
    send_frame(8'd2, 8'h07, 8'h08, 8'h01, 8'h09, 8'h10, SYNC_B, 8'hAB, 0);
    send_frame(8'd3, SYNC_A, SYNC_B, 8'h01, 8'h0A, 8'h00, SYNC_B, SYNC_A, 0);
    send_frame(8'd1, 8'h0B, 8'h0C, 8'h01, 8'h0D, 8'h20, SYNC_B, SYNC_A, 0);
    send_frame(8'd0, 8'h0E, 8'h0F, 8'h01, 8'h11, 8'h00, SYNC_B, SYNC_A, 0);
  endtask

  task automatic test_longest_frame();
    send_frame(8'd255, 8'h5A, 8'hA5, 8'h01, 8'hC3, 8'h00, SYNC_B, SYNC_A, 0);
  endtask

  task automatic test_backpressure();
    sender_gaps = 1'b0;
    rx_hold_req = 80;
    repeat (3) send_frame(8'd6, 8'($urandom), 8'($urandom), 8'h01, 8'($urandom),
                          8'h00, SYNC_B, SYNC_A, 0);
    wait_for_results();
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_traffic(input int n_bytes);
    int start;
    int pick;
    logic [7:0] len;
    logic [7:0] ack;
    logic [7:0] flip;
    logic [7:0] trl1;
    logic [7:0] trl2;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      sender_gaps = ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 4)) send_byte(noise_byte());
      end else if (pick < 12) begin
        // sync byte then a noise byte, which can abort the sync
        send_byte(SYNC_A);
        send_byte(noise_byte());
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 80) len = 8'($urandom_range(4, 12));
        else if (pick < 92) len = 8'($urandom_range(0, 3));
        else len = 8'($urandom_range(13, 40));
        ack = ($urandom_range(0, 1) != 0) ? 8'($urandom) : 8'h00;
        flip = ($urandom_range(0, 99) < 15) ? 8'($urandom_range(1, 255)) : 8'h00;
        trl1 = ($urandom_range(0, 99) < 6) ? 8'($urandom) : SYNC_B;
        trl2 = ($urandom_range(0, 99) < 6) ? 8'($urandom) : SYNC_A;
        send_frame(len, 8'($urandom), 8'($urandom), ack, 8'($urandom), flip, trl1, trl2,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_hunting();
    test_good_frames();
    test_status_codes();
    test_longest_frame();
    test_backpressure();
    test_random_traffic(60);
    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
